>>> hw/rtl/mrt_pkg.sv
// ----------------------------------------------------------------------------
// mrt_pkg
// shared types, register indexes and arithmetic constants of the matte
// recovery and tint pipeline
// ----------------------------------------------------------------------------
package mrt_pkg;

    localparam int CH = 3;

    // register indexes of the configuration port
    localparam logic [1:0] CFG_TARGET_RED   = 2'd0;
    localparam logic [1:0] CFG_TARGET_GREEN = 2'd1;
    localparam logic [1:0] CFG_TARGET_BLUE  = 2'd2;
    localparam logic [1:0] CFG_KEEP_LUM     = 2'd3;

    // reset values of the tint target
    localparam logic [7:0] TARGET_RED_RST   = 8'd229;
    localparam logic [7:0] TARGET_GREEN_RST = 8'd72;
    localparam logic [7:0] TARGET_BLUE_RST  = 8'd77;

    // x/3 for x < 2048 as (x*683) >> 11
    localparam logic [9:0]  DIV3_RECIP = 10'd683;
    localparam int          DIV3_SHIFT = 11;

    // rec.709 weights, sum scaled by 10000
    localparam logic [13:0] LUM_K_RED   = 14'd2126;
    localparam logic [13:0] LUM_K_GREEN = 14'd7152;
    localparam logic [13:0] LUM_K_BLUE  = 14'd722;

    // x/10000 for x < 2^22 as (x*6871948) >> 36
    localparam logic [22:0] LUM_RECIP = 23'd6871948;
    localparam int          LUM_SHIFT = 36;

    // rounding and x/255 for 16-bit x as (x*32897) >> 23
    localparam logic [15:0] ROUND_HALF    = 16'd127;
    localparam logic [15:0] DIV255_RECIP  = 16'd32897;
    localparam int          DIV255_SHIFT  = 23;

    // divider: quotient bits split over the stages
    localparam int DIV_STAGES = 4;
    localparam int DIV_STEPS  = 2;

    localparam int TINT_STAGES = 4;

    typedef struct packed {
        logic [7:0] black_red;
        logic [7:0] black_green;
        logic [7:0] black_blue;
        logic [7:0] white_red;
        logic [7:0] white_green;
        logic [7:0] white_blue;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] out_alpha;
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
    } t_pix_out;

    // matte stage to divider: index 0 is red
    typedef struct packed {
        logic [CH-1:0][7:0] black;
        logic [7:0]         cov;
        logic               zero;
    } t_mat;

    // divider to tint: recovered source and alpha
    typedef struct packed {
        logic [CH-1:0][7:0] src;
        logic [7:0]         alpha;
    } t_src;

endpackage

>>> hw/rtl/mrt_matte.sv
// ----------------------------------------------------------------------------
// mrt_matte
// coverage from the black and white renderings, one register stage
// ----------------------------------------------------------------------------
module mrt_matte (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_keep,
    input  mrt_pkg::t_pix_in i_pix,
    input  logic            i_valid,
    output logic            o_ready,
    output mrt_pkg::t_mat   o_mat,
    output logic            o_valid,
    input  logic            i_ready
);
    import mrt_pkg::*;

    logic [CH-1:0][7:0] blk;
    logic [CH-1:0][7:0] wht;
    logic               inv;
    logic [9:0]         sum;
    logic [18:0]        prod;
    logic [7:0]         third;
    t_mat               n_mat;
    t_mat               r_mat;
    logic               r_valid;

    assign blk = {i_pix.black_blue, i_pix.black_green, i_pix.black_red};
    assign wht = {i_pix.white_blue, i_pix.white_green, i_pix.white_red};

    always_comb begin
        inv = 1'b0;
        sum = '0;
        for (int c = 0; c < CH; c++) begin
            if (wht[c] < blk[c]) begin
                inv = 1'b1;
            end else begin
                sum = sum + 10'(wht[c] - blk[c]);
            end
        end
        // sum/3 by reciprocal
        prod  = 19'(sum) * 19'(DIV3_RECIP);
        third = prod[DIV3_SHIFT +: 8];

        n_mat.black = blk;
        n_mat.cov   = inv ? 8'hFF : 8'hFF - third;
        // flat colour: source forced to black gives lum 0 and the plain target
        n_mat.zero  = ~i_keep | inv | (n_mat.cov == 8'd0);
    end

    assign o_ready = ~r_valid | i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_mat <= n_mat;
        end
    end

    assign o_mat   = r_mat;
    assign o_valid = r_valid;

endmodule

>>> hw/rtl/mrt_div.sv
// ----------------------------------------------------------------------------
// mrt_div
// pipelined restoring divider, black*255/coverage on three channels
// ----------------------------------------------------------------------------
module mrt_div (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  mrt_pkg::t_mat i_mat,
    input  logic          i_valid,
    output logic          o_ready,
    output mrt_pkg::t_src o_src,
    output logic          o_valid,
    input  logic          i_ready
);
    import mrt_pkg::*;

    typedef struct packed {
        logic [CH-1:0][7:0] rem;
        logic [CH-1:0][7:0] low;
        logic [CH-1:0][7:0] quo;
        logic [CH-1:0]      sat;
        logic [7:0]         cov;
        logic               zero;
    } t_dst;

    // one quotient bit on every channel
    function automatic t_dst div_step(input t_dst s);
        t_dst       r;
        logic [8:0] t;
        r = s;
        for (int c = 0; c < CH; c++) begin
            t = {s.rem[c], s.low[c][7]};
            r.low[c] = {s.low[c][6:0], 1'b0};
            if (t >= {1'b0, s.cov}) begin
                r.rem[c] = 8'(t - {1'b0, s.cov});
                r.quo[c] = {s.quo[c][6:0], 1'b1};
            end else begin
                r.rem[c] = t[7:0];
                r.quo[c] = {s.quo[c][6:0], 1'b0};
            end
        end
        return r;
    endfunction

    logic [DIV_STAGES:0]   rdy;
    logic [DIV_STAGES-1:0] r_vld;
    t_dst                  r_st [DIV_STAGES];
    t_dst                  n_st [DIV_STAGES];
    t_dst                  entry;
    t_dst                  cur;
    logic [15:0]           num;
    t_dst                  last;

    always_comb begin
        rdy[DIV_STAGES] = i_ready;
        for (int k = DIV_STAGES - 1; k >= 0; k--) begin
            rdy[k] = ~r_vld[k] | rdy[k+1];
        end
    end

    always_comb begin
        entry = '0;
        num   = '0;
        for (int c = 0; c < CH; c++) begin
            num = {i_mat.black[c], 8'd0} - {8'd0, i_mat.black[c]};
            entry.rem[c] = num[15:8];
            entry.low[c] = num[7:0];
            // quotient of 255 or more saturates
            entry.sat[c] = i_mat.black[c] >= i_mat.cov;
        end
        entry.cov  = i_mat.cov;
        entry.zero = i_mat.zero;

        for (int k = 0; k < DIV_STAGES; k++) begin
            cur = (k == 0) ? entry : r_st[k-1];
            for (int j = 0; j < DIV_STEPS; j++) begin
                cur = div_step(cur);
            end
            n_st[k] = cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < DIV_STAGES; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= (k == 0) ? i_valid : r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (rdy[k]) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    assign last = r_st[DIV_STAGES-1];

    always_comb begin
        for (int c = 0; c < CH; c++) begin
            if (last.zero) begin
                o_src.src[c] = 8'd0;
            end else if (last.sat[c]) begin
                o_src.src[c] = 8'hFF;
            end else begin
                o_src.src[c] = last.quo[c];
            end
        end
        o_src.alpha = last.cov;
    end

    assign o_ready = rdy[0];
    assign o_valid = r_vld[DIV_STAGES-1];

endmodule

>>> hw/rtl/mrt_tint.sv
// ----------------------------------------------------------------------------
// mrt_tint
// rec.709 luminance of the source and tint of the target toward white
// ----------------------------------------------------------------------------
module mrt_tint (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [2:0][7:0]   i_target,
    input  mrt_pkg::t_src     i_src,
    input  logic              i_valid,
    output logic              o_ready,
    output mrt_pkg::t_pix_out o_pix,
    output logic              o_valid,
    input  logic              i_ready
);
    import mrt_pkg::*;

    logic [TINT_STAGES:0]   rdy;
    logic [TINT_STAGES-1:0] r_vld;

    logic [21:0]            n_wsum;
    logic [21:0]            r_wsum;
    logic [44:0]            lum_prod;
    logic [7:0]             r_lum;
    logic [CH-1:0][15:0]    n_x;
    logic [CH-1:0][15:0]    r_x;
    logic [31:0]            q_prod [CH];
    logic [CH-1:0][7:0]     n_col;
    logic [7:0]             r_alpha [TINT_STAGES-1];
    t_pix_out               r_out;

    always_comb begin
        rdy[TINT_STAGES] = i_ready;
        for (int k = TINT_STAGES - 1; k >= 0; k--) begin
            rdy[k] = ~r_vld[k] | rdy[k+1];
        end
    end

    // weighted sum, luminance scaled by 10000
    assign n_wsum = 22'(i_src.src[0]) * 22'(LUM_K_RED)
                  + 22'(i_src.src[1]) * 22'(LUM_K_GREEN)
                  + 22'(i_src.src[2]) * 22'(LUM_K_BLUE);

    assign lum_prod = 45'(r_wsum) * 45'(LUM_RECIP);

    always_comb begin
        for (int c = 0; c < CH; c++) begin
            n_x[c] = 16'(8'hFF - i_target[c]) * 16'(r_lum) + ROUND_HALF;
            q_prod[c] = 32'(r_x[c]) * 32'(DIV255_RECIP);
            n_col[c]  = i_target[c] + q_prod[c][DIV255_SHIFT +: 8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < TINT_STAGES; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= (k == 0) ? i_valid : r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_wsum     <= n_wsum;
            r_alpha[0] <= i_src.alpha;
        end
        if (rdy[1]) begin
            r_lum      <= lum_prod[LUM_SHIFT +: 8];
            r_alpha[1] <= r_alpha[0];
        end
        if (rdy[2]) begin
            r_x        <= n_x;
            r_alpha[2] <= r_alpha[1];
        end
        if (rdy[3]) begin
            r_out.out_alpha <= r_alpha[2];
            r_out.out_red   <= n_col[0];
            r_out.out_green <= n_col[1];
            r_out.out_blue  <= n_col[2];
        end
    end

    assign o_pix   = r_out;
    assign o_ready = rdy[0];
    assign o_valid = r_vld[TINT_STAGES-1];

endmodule

>>> hw/rtl/matte_recover_and_tint_pixel_core.sv
// ----------------------------------------------------------------------------
// matte_recover_and_tint_pixel_core
// difference matting: alpha from a pixel over black and over white, then
// the source colour recovered and its luminance used to tint a target
// ----------------------------------------------------------------------------
// usage
//   pixel in  : i_pix with i_pix_valid / o_pix_ready, one word per pixel
//   result out: o_res with o_res_valid / i_res_ready, one word per pixel
//   config    : i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data,
//               written only while the pipe is empty; o_cfg_ready is always
//               high
//   stages    : 1 matte stage, 4 divider stages of 2 quotient bits,
//               4 tint stages
//   throughput: one pixel per cycle, set by the nine register stages each
//               taking a new word whenever its own slot is free
//   reset     : synchronous, active low; pipe emptied, target back to
//               229/72/77 and luminance tint off
//   stall     : when i_res_ready is low the last stage holds its word; the
//               stages behind still fill their empty slots, so words keep
//               being accepted until the whole pipe is full
// ----------------------------------------------------------------------------
module matte_recover_and_tint_pixel_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // pixel channel
    input  mrt_pkg::t_pix_in  i_pix,
    input  logic              i_pix_valid,
    output logic              o_pix_ready,
    // result channel
    output mrt_pkg::t_pix_out o_res,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    // configuration write channel
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [7:0]        i_cfg_data
);
    import mrt_pkg::*;

    // configuration registers, index 0 is red
    logic [CH-1:0][7:0] r_target;
    logic               r_keep;

    // stage links
    t_mat               mat;
    logic               mat_valid;
    logic               mat_ready;
    t_src               src;
    logic               src_valid;
    logic               src_ready;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target[0] <= TARGET_RED_RST;
            r_target[1] <= TARGET_GREEN_RST;
            r_target[2] <= TARGET_BLUE_RST;
            r_keep      <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TARGET_RED:   r_target[0] <= i_cfg_data;
                CFG_TARGET_GREEN: r_target[1] <= i_cfg_data;
                CFG_TARGET_BLUE:  r_target[2] <= i_cfg_data;
                CFG_KEEP_LUM:     r_keep      <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // coverage, inversion check and flat-colour decision
    mrt_matte u_matte (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_keep  (r_keep),
        .i_pix   (i_pix),
        .i_valid (i_pix_valid),
        .o_ready (o_pix_ready),
        .o_mat   (mat),
        .o_valid (mat_valid),
        .i_ready (mat_ready)
    );

    // source recovery, saturating at 255, black at zero coverage
    mrt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mat   (mat),
        .i_valid (mat_valid),
        .o_ready (mat_ready),
        .o_src   (src),
        .o_valid (src_valid),
        .i_ready (src_ready)
    );

    // luminance and rounded tint toward white
    mrt_tint u_tint (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_target (r_target),
        .i_src    (src),
        .i_valid  (src_valid),
        .o_ready  (src_ready),
        .o_pix    (o_res),
        .o_valid  (o_res_valid),
        .i_ready  (i_res_ready)
    );

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives pixel words into the matte recovery and tint core and checks every
// result word against an in-bench model of coverage, source recovery and
// luminance tint, across several tint targets and idle patterns
// ----------------------------------------------------------------------------
module testbench;

    import mrt_pkg::*;

    // settle wait after draining, sized by the register stages of the core
    localparam int PIPE_LATENCY = 9;
    localparam int WORDS_PER_PHASE = 75;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_STALL, IDLE_BOTH} idle_mode_e;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always #5 i_clk = ~i_clk;

    // stimulus side of the ports, all known from time zero
    t_pix_in    pix_word  = '0;
    logic       pix_valid = 1'b0;
    logic       res_ready = 1'b0;
    logic       cfg_valid = 1'b0;
    logic [1:0] cfg_index = CFG_TARGET_RED;
    logic [7:0] cfg_data  = '0;

    wire        o_pix_ready;
    t_pix_out   o_res;
    wire        o_res_valid;
    wire        o_cfg_ready;

    matte_recover_and_tint_pixel_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix       (pix_word),
        .i_pix_valid (pix_valid),
        .o_pix_ready (o_pix_ready),
        .o_res       (o_res),
        .o_res_valid (o_res_valid),
        .i_res_ready (res_ready),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // mirror of the tint registers, starting from their reset values
    logic [7:0] tgt_mirror [3] = '{TARGET_RED_RST, TARGET_GREEN_RST, TARGET_BLUE_RST};
    logic       keep_mirror    = 1'b0;

    // words waiting to be sent and tinted pixels still owed by the core
    t_pix_in  pixel_queue [$];
    t_pix_out due_pixels  [$];

    int send_idle_pct  = 0;
    int stall_pct      = 0;
    int mismatch_count = 0;

    // lsb first, matching the packed order of the result word
    string field_name [4] = '{"blue", "green", "red", "alpha"};

    // expected result word for one pixel under the current register mirror
    function automatic t_pix_out tint_pixel(t_pix_in px);
        int unsigned blk [3];
        int unsigned wht [3];
        int unsigned src [3];
        int unsigned col [3];
        int unsigned sum, cov, lum, tgt;
        bit          inv;
        int          k;
        t_pix_out    res;
        blk = '{px.black_red, px.black_green, px.black_blue};
        wht = '{px.white_red, px.white_green, px.white_blue};
        sum = 0;
        inv = 1'b0;
        for (k = 0; k < 3; k++) begin
            // a channel darker over white than over black marks an inverted pixel
            if (wht[k] < blk[k]) begin
                inv = 1'b1;
            end else begin
                sum += wht[k] - blk[k];
            end
        end
        cov = inv ? 255 : 255 - sum / 3;
        if (!keep_mirror || inv) begin
            for (k = 0; k < 3; k++) col[k] = tgt_mirror[k];
        end else begin
            for (k = 0; k < 3; k++) begin
                // zero coverage recovers black, otherwise saturate at full scale
                if (cov == 0) begin
                    src[k] = 0;
                end else begin
                    src[k] = blk[k] * 255 / cov;
                    if (src[k] > 255) src[k] = 255;
                end
            end
            // rec.709 luminance scaled by ten thousand
            lum = (src[0] * 2126 + src[1] * 7152 + src[2] * 722) / 10000;
            for (k = 0; k < 3; k++) begin
                tgt    = tgt_mirror[k];
                col[k] = tgt + ((255 - tgt) * lum + 127) / 255;
            end
        end
        res.out_alpha = cov[7:0];
        res.out_red   = col[0][7:0];
        res.out_green = col[1][7:0];
        res.out_blue  = col[2][7:0];
        return res;
    endfunction

    // mostly plausible renderings of a source colour at some coverage, the
    // rest raw noise that is often inverted
    function automatic t_pix_in random_pixel();
        logic [7:0]  b [3];
        logic [7:0]  w [3];
        int unsigned cov, src, blk;
        int          wht;
        int          k;
        t_pix_in     px;
        if ($urandom_range(99) < 15) begin
            px = 48'({$urandom(), $urandom()});
        end else begin
            // lean on the near-transparent end where recovery saturates
            cov = ($urandom_range(99) < 20) ? $urandom_range(4) : $urandom_range(255);
            for (k = 0; k < 3; k++) begin
                src = $urandom_range(255);
                blk = src * cov / 255;
                wht = int'(blk + 255 - cov) + int'($urandom_range(6)) - 3;
                if (wht < int'(blk)) wht = blk;
                if (wht > 255) wht = 255;
                b[k] = blk[7:0];
                w[k] = wht[7:0];
            end
            px = '{b[0], b[1], b[2], w[0], w[1], w[2]};
        end
        return px;
    endfunction

    // pixel driver: holds a word until taken, then maybe idles before the next
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_valid <= 1'b0;
        end else begin
            if (pix_valid && o_pix_ready) begin
                due_pixels.push_back(tint_pixel(pix_word));
            end
            if (!pix_valid || o_pix_ready) begin
                if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    pix_word  <= pixel_queue.pop_front();
                    pix_valid <= 1'b1;
                end else begin
                    pix_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor: compares each taken word with the oldest one owed
    always @(posedge i_clk) begin : result_check
        t_pix_out        want;
        logic [3:0][7:0] want_b;
        logic [3:0][7:0] got_b;
        int              k;
        if (!i_rst_n) begin
            res_ready <= 1'b0;
        end else begin
            if (o_res_valid && res_ready) begin
                if (due_pixels.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result word %h with nothing expected", $time, o_res);
                end else begin
                    want   = due_pixels.pop_front();
                    want_b = want;
                    got_b  = o_res;
                    for (k = 3; k >= 0; k--) begin
                        if (got_b[k] !== want_b[k]) begin
                            mismatch_count++;
                            $display("%0t: %s expected %0d, got %0d", $time,
                                     field_name[k], want_b[k], got_b[k]);
                        end
                    end
                end
            end
            res_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic set_idle(input idle_mode_e mode);
        case (mode)
            IDLE_NONE:  begin send_idle_pct = 0;  stall_pct = 0;  end
            IDLE_SEND:  begin send_idle_pct = 86; stall_pct = 0;  end
            IDLE_STALL: begin send_idle_pct = 0;  stall_pct = 86; end
            IDLE_BOTH:  begin send_idle_pct = 11; stall_pct = 11; end
        endcase
    endtask

    // wait at the falling edge until every word is sent and answered
    task automatic drain();
        @(negedge i_clk);
        while (pixel_queue.size() != 0 || pix_valid || due_pixels.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic settle();
        drain();
        repeat (PIPE_LATENCY) @(negedge i_clk);
    endtask

    // one register write on the configuration channel, mirror follows on
    // acceptance keeping only the register's own bits
    task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_TARGET_RED:   tgt_mirror[0] = data;
            CFG_TARGET_GREEN: tgt_mirror[1] = data;
            CFG_TARGET_BLUE:  tgt_mirror[2] = data;
            CFG_KEEP_LUM:     keep_mirror   = data[0];
        endcase
    endtask

    task automatic configure(input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b, input logic [7:0] keep);
        write_reg(CFG_TARGET_RED, r);
        write_reg(CFG_TARGET_GREEN, g);
        write_reg(CFG_TARGET_BLUE, b);
        write_reg(CFG_KEEP_LUM, keep);
    endtask

    task automatic push_pixel(input logic [7:0] br, input logic [7:0] bg,
                              input logic [7:0] bb, input logic [7:0] wr,
                              input logic [7:0] wg, input logic [7:0] wb);
        pixel_queue.push_back(t_pix_in'{br, bg, bb, wr, wg, wb});
    endtask

    task automatic push_directed();
        push_pixel(8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0);    // opaque black
        push_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);  // opaque white
        push_pixel(8'd0,   8'd0,   8'd0,   8'd255, 8'd255, 8'd255);  // zero coverage
        push_pixel(8'd1,   8'd0,   8'd0,   8'd255, 8'd254, 8'd254);  // coverage one
        push_pixel(8'd100, 8'd0,   8'd0,   8'd255, 8'd255, 8'd255);  // recovery overflow
        push_pixel(8'd10,  8'd20,  8'd30,  8'd9,   8'd200, 8'd200);  // inverted red
        push_pixel(8'd50,  8'd60,  8'd70,  8'd60,  8'd59,  8'd80);   // inverted green
        push_pixel(8'd0,   8'd0,   8'd255, 8'd0,   8'd0,   8'd254);  // inverted blue
        push_pixel(8'd0,   8'd0,   8'd0,   8'd1,   8'd1,   8'd0);    // mean truncates to 0
        push_pixel(8'd0,   8'd0,   8'd0,   8'd1,   8'd1,   8'd1);    // mean of exactly 1
        push_pixel(8'd128, 8'd64,  8'd32,  8'd192, 8'd128, 8'd96);   // mid coverage
        push_pixel(8'd255, 8'd0,   8'd255, 8'd255, 8'd255, 8'd255);  // mixed saturation
        push_pixel(8'd170, 8'd85,  8'd42,  8'd170, 8'd85,  8'd42);   // opaque colour
    endtask

    // overall run limit, far beyond the slowest correct run
    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        int p;
        int n;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // flat colour from the reset target, then luminance tint on
        set_idle(IDLE_NONE);
        push_directed();
        settle();
        configure(8'd0, 8'd255, 8'd128, 8'h01);
        push_directed();
        settle();

        for (p = 0; p < 6; p++) begin
            case (p)
                0: configure(8'd0, 8'd0, 8'd0, 8'hFF);
                1: configure(8'd255, 8'd255, 8'd255, 8'h01);
                2: configure(8'($urandom()), 8'($urandom()), 8'($urandom()), 8'hFE);
                3: configure(8'($urandom()), 8'($urandom()), 8'($urandom()), 8'h81);
                4: configure(8'($urandom()), 8'($urandom()), 8'($urandom()),
                             8'($urandom()));
                default: configure(TARGET_RED_RST, TARGET_GREEN_RST, TARGET_BLUE_RST,
                                   8'h01);
            endcase
            set_idle(idle_mode_e'(p % 4));
            if (p == 4) begin
                // hold the sender back once until the pipe has run dry
                for (n = 0; n < 35; n++) pixel_queue.push_back(random_pixel());
                drain();
                for (n = 35; n < WORDS_PER_PHASE; n++) pixel_queue.push_back(random_pixel());
            end else begin
                for (n = 0; n < WORDS_PER_PHASE; n++) pixel_queue.push_back(random_pixel());
            end
            settle();
        end

        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
